@@ hdl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by every module under hdl.
package spq_pkg;

  localparam int ValueW    = 32;
  localparam int PrioW     = 16;
  localparam int CountOutW = 4;
  localparam int StatusW   = 2;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 72;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef enum logic {
    SPQ_IDLE,
    SPQ_EXEC
  } spq_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } spq_cmd_t;

  typedef struct packed {
    logic out_valid;
  } spq_stat_t;

endpackage

@@ hdl/spq_ctrl.sv @@
// Controller for the sorted priority queue: sequences capture and commit.
// Depends on spq_pkg.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      m_tready,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  spq_state_t state;
  spq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SPQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SPQ_IDLE: begin
        if (s_tvalid) begin
          state_next = SPQ_EXEC;
        end
      end
      SPQ_EXEC: begin
        if (!stat.out_valid || m_tready) begin
          state_next = SPQ_IDLE;
        end
      end
      default: state_next = SPQ_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      SPQ_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      SPQ_EXEC: begin
        cmd.commit = !stat.out_valid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == SPQ_EXEC)
    else $error("capture did not enter execute");

  a_no_cmd_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit together");

  a_commit_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == SPQ_IDLE)
    else $error("commit did not return to idle");

endmodule

@@ hdl/spq_dp.sv @@
// Datapath for the sorted priority queue: shift-register entry store with
// parallel priority compare, input capture and output register.
// Depends on spq_pkg.
module spq_dp
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [InDataW-1:0]  s_tdata,
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic [StatusW-1:0]  m_tuser,
  input  spq_cmd_t            cmd,
  output spq_stat_t           stat
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic                     in_mode;
  logic signed [ValueW-1:0] in_val;
  logic signed [PrioW-1:0]  in_pri;

  logic signed [ValueW-1:0] val      [QUEUE_DEPTH];
  logic signed [PrioW-1:0]  pri      [QUEUE_DEPTH];
  logic signed [ValueW-1:0] val_next [QUEUE_DEPTH];
  logic signed [PrioW-1:0]  pri_next [QUEUE_DEPTH];
  logic signed [ValueW-1:0] val_dn   [QUEUE_DEPTH];
  logic signed [PrioW-1:0]  pri_dn   [QUEUE_DEPTH];
  logic signed [ValueW-1:0] val_up   [QUEUE_DEPTH];
  logic signed [PrioW-1:0]  pri_up   [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0]   ge;
  logic [QUEUE_DEPTH-1:0]   ge_prev;
  logic [CntW-1:0]          count;
  logic [CntW-1:0]          count_next;
  logic                     full;
  logic signed [ValueW-1:0] removed;
  logic [StatusW-1:0]       status;
  logic signed [ValueW-1:0] front;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_mode <= s_tuser;
      in_val  <= s_tdata[ValueW-1:0];
      in_pri  <= s_tdata[ValueW+PrioW-1:ValueW];
    end
  end

  // Held entries sit at or ahead of a new one of equal or lower priority.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (count > CntW'(i)) && (pri[i] >= in_pri);
    end
  end

  assign ge_prev = {ge[QUEUE_DEPTH-2:0], 1'b1};
  assign full    = count == CntW'(QUEUE_DEPTH);

  always_comb begin
    val_dn[0] = in_val;
    pri_dn[0] = in_pri;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      val_dn[i] = val[i-1];
      pri_dn[i] = pri[i-1];
    end
    val_up[QUEUE_DEPTH-1] = val[QUEUE_DEPTH-1];
    pri_up[QUEUE_DEPTH-1] = pri[QUEUE_DEPTH-1];
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      val_up[i] = val[i+1];
      pri_up[i] = pri[i+1];
    end
  end

  always_comb begin
    val_next   = val;
    pri_next   = pri;
    count_next = count;
    removed    = '0;
    status     = STATUS_OK;
    if (in_mode == MODE_ENQ) begin
      if (full) begin
        status = STATUS_OVERFLOW;
      end else begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!ge[i]) begin
            if (ge_prev[i]) begin
              val_next[i] = in_val;
              pri_next[i] = in_pri;
            end else begin
              val_next[i] = val_dn[i];
              pri_next[i] = pri_dn[i];
            end
          end
        end
        count_next = count + 1'b1;
      end
    end else begin
      if (count == '0) begin
        status = STATUS_UNDERFLOW;
      end else begin
        removed    = val[0];
        val_next   = val_up;
        pri_next   = pri_up;
        count_next = count - 1'b1;
      end
    end
  end

  assign front = (count_next != '0) ? val_next[0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      val     <= val_next;
      pri     <= pri_next;
      m_tdata <= {2'b00,
                  count_next == CntW'(QUEUE_DEPTH),
                  CountOutW'(count_next),
                  count_next != '0,
                  front,
                  removed};
      m_tuser <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign stat.out_valid = m_tvalid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(count))
    else $error("count moved without commit");

  a_commit_output: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("commit did not present a result");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result overwritten while stalled");

endmodule

@@ hdl/sorted_priority_queue.sv @@
// Sorted priority queue, top level: bounded queue kept in descending
// priority order, FIFO order among equal priorities.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Input stream (s_*): one transfer per operation. s_tuser selects enqueue
// (0) or dequeue (1); s_tdata carries the value and priority to enqueue.
// Output stream (m_*): exactly one transfer per operation, in order,
// carrying the removed value, front value and flag, count and full flag;
// m_tuser carries the status (ok, overflow, underflow).
// The input transfer loads the capture register and enters execute; execute
// registers the result once the output register is free, and m_tvalid rises.
// Inputs are taken only in idle, so a new operation waits until the last one
// has committed its shift/insert over the entry registers.
// An input is taken while the previous result still waits on m_tready; its
// commit then waits until the output register is free.
// Reset empties the queue and drops any pending result; entry contents are
// left as they are and never read until rewritten.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,  // item_value[31:0], item_priority[47:32]
  input  logic                s_tuser,  // mode[0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,  // removed_value[31:0], front_value[63:32],
                                        // front_valid[64], entry_count[68:65],
                                        // queue_full[69], zero[71:70]
  output logic [StatusW-1:0]  m_tuser   // status[1:0]
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for sorted_priority_queue: directed and random streams of enqueues
// and dequeues, every result compared against an in-bench sorted-array model of the queue.
// Depends on hdl/spq_pkg.sv and hdl/sorted_priority_queue.sv.
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  localparam int QDEPTH = 8;

  typedef struct {
    logic [ValueW-1:0]    removed;
    logic [StatusW-1:0]   status;
    logic [ValueW-1:0]    front;
    logic                 fvalid;
    logic [CountOutW-1:0] count;
    logic                 full;
  } queue_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = MODE_ENQ;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic [StatusW-1:0]  m_tuser;

  // shadow copy of the queue, front first
  logic [ValueW-1:0]        q_val [QDEPTH];
  logic signed [PrioW-1:0]  q_pri [QDEPTH];
  int                       q_cnt = 0;

  queue_result_t exp_results[$];

  int  err_cnt = 0;
  int  n_enq = 0, n_deq = 0, n_ovf = 0, n_udf = 0, n_full = 0, n_checked = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  bit  rx_hold_req = 1'b0;
  int  rx_hold_len = 120;

  sorted_priority_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic queue_result_t queue_apply(input logic mode, input logic [ValueW-1:0] val,
                                                input logic signed [PrioW-1:0] pri);
    queue_result_t r;
    int pos;
    int k;
    r = '{default: '0};
    if (mode == MODE_ENQ) begin
      if (q_cnt >= QDEPTH) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        pos = q_cnt;
        while (pos > 0 && q_pri[pos-1] < pri) begin
          q_val[pos] = q_val[pos-1];
          q_pri[pos] = q_pri[pos-1];
          pos--;
        end
        q_val[pos] = val;
        q_pri[pos] = pri;
        q_cnt++;
      end
    end else begin
      if (q_cnt == 0) begin
        r.status = STATUS_UNDERFLOW;
      end else begin
        r.removed = q_val[0];
        for (k = 0; k + 1 < q_cnt; k++) begin
          q_val[k] = q_val[k+1];
          q_pri[k] = q_pri[k+1];
        end
        q_cnt--;
      end
    end
    r.front  = (q_cnt > 0) ? q_val[0] : '0;
    r.fvalid = (q_cnt > 0);
    r.count  = q_cnt[CountOutW-1:0];
    r.full   = (q_cnt == QDEPTH);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ValueW-1:0] want,
                             input logic [ValueW-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // predicts on each input transfer, checks each output transfer
  always @(posedge clk) begin : monitor
    queue_result_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        e = queue_apply(s_tuser, s_tdata[31:0], s_tdata[47:32]);
        exp_results.push_back(e);
        if (s_tuser == MODE_ENQ) n_enq++;
        else n_deq++;
        if (e.status == STATUS_OVERFLOW) n_ovf++;
        if (e.status == STATUS_UNDERFLOW) n_udf++;
        if (e.full) n_full++;
      end
      if (m_tvalid && m_tready) begin
        if (exp_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result transfer with nothing expected, actual %h / %h",
                   $time, m_tdata, m_tuser);
        end else begin
          e = exp_results.pop_front();
          n_checked++;
          check_field("removed_value", e.removed, m_tdata[31:0]);
          check_field("front_value", e.front, m_tdata[63:32]);
          check_field("front_valid", ValueW'(e.fvalid), ValueW'(m_tdata[64]));
          check_field("entry_count", ValueW'(e.count), ValueW'(m_tdata[68:65]));
          check_field("queue_full", ValueW'(e.full), ValueW'(m_tdata[69]));
          check_field("pad bits", '0, ValueW'(m_tdata[71:70]));
          check_field("status", ValueW'(e.status), ValueW'(m_tuser));
        end
      end
    end
  end

  initial begin : receiver
    int n;
    m_tready = 1'b0;
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic mode, input logic [ValueW-1:0] val,
                           input logic [PrioW-1:0] pri);
    int gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {pri, val};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (exp_results.size() != 0);
  endtask

  task automatic test_empty_dequeue();
    send_item(MODE_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drain();
  endtask

  // fill with extreme values and tied priorities, overflow, then empty out past the bottom
  task automatic test_fill_and_empty();
    logic [ValueW-1:0] vals [QDEPTH] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                         32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_A5A5,
                                         32'h5A5A_5A5A, 32'h0000_0001};
    logic [PrioW-1:0]  pris [QDEPTH] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000,
                                         16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001};
    int i;
    for (i = 0; i < QDEPTH; i++) send_item(MODE_ENQ, vals[i], pris[i]);
    send_item(MODE_ENQ, 32'hDEAD_BEEF, 16'h7FFF);
    for (i = 0; i <= QDEPTH; i++) send_item(MODE_DEQ, $urandom, PrioW'($urandom));
    wait_drain();
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int i;
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    for (i = 0; i < 30; i++) begin
      if (i % 4 == 3) send_item(MODE_DEQ, $urandom, PrioW'($urandom));
      else send_item(MODE_ENQ, $urandom, PrioW'($urandom_range(0, 3)));
    end
    wait_drain();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic(input int n_items);
    int i;
    int enq_pct;
    int prio_kind;
    logic [PrioW-1:0] pri;
    logic mode;
    for (i = 0; i < n_items; i++) begin
      if (i % 32 == 0) begin
        enq_pct   = $urandom_range(15, 85);
        prio_kind = $urandom_range(0, 2);
      end
      if (i % 100 == 0) begin
        tx_idle_en = ($urandom_range(0, 2) != 0);
        rx_idle_en = ($urandom_range(0, 2) != 0);
      end
      if (i >= n_items - 200) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
      case (prio_kind)
        0: pri = PrioW'($urandom_range(0, 3));
        1: pri = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        default: pri = PrioW'($urandom);
      endcase
      send_item(mode, $urandom, pri);
    end
    wait_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_dequeue();
    test_fill_and_empty();
    test_backpressure();
    test_random_traffic(1300);
    repeat (10) @(posedge clk);
    $display("Checked %0d results: %0d enqueues, %0d dequeues, %0d overflows, %0d underflows,",
             n_checked, n_enq, n_deq, n_ovf, n_udf);
    $display("%0d results reported a full queue; long output stall with input backpressure.",
             n_full);
    if (err_cnt == 0 && exp_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", exp_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
